// ----- rtl/core/text_mode_character_generator_top_assert.svh -----
// Assertion macros for the text-mode character generator checker.
`ifndef TEXT_MODE_CHARACTER_GENERATOR_TOP_ASSERT_SVH
`define TEXT_MODE_CHARACTER_GENERATOR_TOP_ASSERT_SVH

// Concurrent check on the rising clock edge, off while reset is held.
`define TMCG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TMCG_ASSERT_NEXT(name, ante, cons, msg) \
  `TMCG_ASSERT(name, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/tmcg_pkg.sv -----
// Shared types and constants for the text-mode character generator.
`timescale 1ns / 1ps

package tmcg_pkg;

  localparam int COLUMNS_DEF       = 80;
  localparam int ROWS_DEF          = 25;
  localparam int LINES_PER_ROW_DEF = 10;
  localparam int SCREEN_DEPTH_DEF  = 2048;

  localparam int OP_W     = 2;
  localparam int ADDR_W   = 11;
  localparam int DATA_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int LINE_W   = 4;
  localparam int FRAME_W  = 8;
  localparam int CODE_W   = 7;
  localparam int GLYPH_AW = 11;

  localparam logic [LINE_W-1:0] BLANK_LINE  = 4'd9;
  localparam int                FLASH_BIT   = 7;
  localparam int                FLASH_PHASE = 3;
  localparam logic [DATA_W-1:0] SPACE_CODE  = 8'h20;

  typedef enum logic [OP_W-1:0] {
    OP_SCREEN_WR = 2'd0,
    OP_GLYPH_WR  = 2'd1,
    OP_TICK      = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GLYPH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic scr_we;
    logic glyph_we;
    logic tick;
    logic glyph_rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

endpackage

// ----- rtl/core/tmcg_ctrl.sv -----
// Controller state machine: clearing pass, beat decode and tick sequencing.
`timescale 1ns / 1ps

module tmcg_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tmcg_pkg::OP_W-1:0]      op_i,
  input  tmcg_pkg::status_t              status_i,
  output tmcg_pkg::cmd_t                 cmd_o,
  output logic                           busy_o
);

  tmcg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmcg_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      tmcg_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = tmcg_pkg::ST_IDLE;
      end
      tmcg_pkg::ST_IDLE: begin
        if (start_i) begin
          unique case (tmcg_pkg::op_e'(op_i))
            tmcg_pkg::OP_SCREEN_WR: cmd_o.scr_we = 1'b1;
            tmcg_pkg::OP_GLYPH_WR:  cmd_o.glyph_we = 1'b1;
            tmcg_pkg::OP_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = tmcg_pkg::ST_GLYPH;
            end
            default: ;  // unused code: take the beat, do nothing
          endcase
        end
      end
      tmcg_pkg::ST_GLYPH: begin
        cmd_o.glyph_rd = 1'b1;
        state_d        = tmcg_pkg::ST_OUT;
      end
      tmcg_pkg::ST_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = tmcg_pkg::ST_IDLE;
      end
      default: state_d = tmcg_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != tmcg_pkg::ST_IDLE);

endmodule

// ----- rtl/core/tmcg_datapath.sv -----
// Datapath: screen and glyph memories, raster counters and pixel formation.
`timescale 1ns / 1ps

module tmcg_datapath #(
  parameter int COLUMNS       = tmcg_pkg::COLUMNS_DEF,
  parameter int ROWS          = tmcg_pkg::ROWS_DEF,
  parameter int LINES_PER_ROW = tmcg_pkg::LINES_PER_ROW_DEF,
  parameter int SCREEN_DEPTH  = tmcg_pkg::SCREEN_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tmcg_pkg::cmd_t                 cmd_i,
  output tmcg_pkg::status_t              status_o,
  input  logic [tmcg_pkg::ADDR_W-1:0]    address_i,
  input  logic [tmcg_pkg::DATA_W-1:0]    data_i,
  output logic                           strobe_o,
  output logic [tmcg_pkg::DATA_W-1:0]    pixels_o,
  output logic [tmcg_pkg::COL_W-1:0]     column_o,
  output logic [tmcg_pkg::ROW_W-1:0]     text_row_o,
  output logic [tmcg_pkg::LINE_W-1:0]    scanline_o,
  output logic                           frame_end_o
);

  localparam int SW     = $clog2(SCREEN_DEPTH);
  localparam int ColW   = tmcg_pkg::COL_W;
  localparam int RowW   = tmcg_pkg::ROW_W;
  localparam int LineW  = tmcg_pkg::LINE_W;
  localparam int DataW  = tmcg_pkg::DATA_W;
  localparam int CodeW  = tmcg_pkg::CODE_W;
  localparam int GlyphD = 2 ** tmcg_pkg::GLYPH_AW;

  localparam logic [ColW-1:0]  ColLast  = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0]  RowLast  = RowW'(ROWS - 1);
  localparam logic [LineW-1:0] LineLast = LineW'(LINES_PER_ROW - 1);
  localparam logic [SW-1:0]    CellLast = SW'(SCREEN_DEPTH - 1);

  logic [DataW-1:0] scr_mem   [SCREEN_DEPTH];
  logic [DataW-1:0] glyph_mem [GlyphD];

  logic [SW-1:0]                   clr_addr_q, clr_addr_d;
  logic [SW-1:0]                   cell_q, cell_d, row_start_q, row_start_d, cell_inc;
  logic [ColW-1:0]                 col_q, col_d;
  logic [RowW-1:0]                 row_q, row_d;
  logic [LineW-1:0]                line_q, line_d;
  logic [tmcg_pkg::FRAME_W-1:0]    frame_q, frame_d;
  logic [DataW-1:0]                scr_rd_q, glyph_rd_q, code;
  logic [tmcg_pkg::GLYPH_AW-1:0]   glyph_addr;
  logic                            scr_wr_ok;
  logic                            col_last, line_last, row_last, origin;

  assign col_last  = (col_q == ColLast);
  assign line_last = (line_q == LineLast);
  assign row_last  = (row_q == RowLast);
  assign origin    = (col_q == '0) && (line_q == '0) && (row_q == '0);

  assign scr_wr_ok         = (32'(address_i) < SCREEN_DEPTH);
  assign status_o.clr_last = (clr_addr_q == CellLast);
  assign clr_addr_d        = clr_addr_q + SW'(1);
  assign cell_inc          = (cell_q == CellLast) ? '0 : cell_q + SW'(1);

  // Flashing characters show a space during the odd half of the blink period.
  always_comb begin
    code = scr_rd_q;
    if (scr_rd_q[tmcg_pkg::FLASH_BIT] && frame_q[tmcg_pkg::FLASH_PHASE]) begin
      code = tmcg_pkg::SPACE_CODE;
    end
    glyph_addr = {code[CodeW-1:0], line_q};
  end

  // Step the raster one cell; cell_q tracks row * COLUMNS + column modulo depth.
  always_comb begin
    col_d       = col_q;
    line_d      = line_q;
    row_d       = row_q;
    cell_d      = cell_q;
    row_start_d = row_start_q;
    frame_d     = frame_q;
    if (cmd_i.tick && origin) frame_d = frame_q + 1'b1;
    if (cmd_i.emit) begin
      if (col_last) begin
        col_d = '0;
        if (line_last) begin
          line_d = '0;
          if (row_last) begin
            row_d       = '0;
            cell_d      = '0;
            row_start_d = '0;
          end else begin
            row_d       = row_q + 1'b1;
            cell_d      = cell_inc;
            row_start_d = cell_inc;
          end
        end else begin
          line_d = line_q + 1'b1;
          cell_d = row_start_q;
        end
      end else begin
        col_d  = col_q + 1'b1;
        cell_d = cell_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      cell_q      <= '0;
      row_start_q <= '0;
      col_q       <= '0;
      line_q      <= '0;
      row_q       <= '0;
      frame_q     <= '0;
    end else begin
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_d;
      cell_q      <= cell_d;
      row_start_q <= row_start_d;
      col_q       <= col_d;
      line_q      <= line_d;
      row_q       <= row_d;
      frame_q     <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      scr_mem[clr_addr_q] <= '0;
    end else if (cmd_i.scr_we && scr_wr_ok) begin
      scr_mem[SW'(address_i)] <= data_i;
    end
    if (cmd_i.tick) scr_rd_q <= scr_mem[cell_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.glyph_we) glyph_mem[address_i] <= data_i;
    if (cmd_i.glyph_rd) glyph_rd_q <= glyph_mem[glyph_addr];
  end

  assign strobe_o    = cmd_i.emit;
  assign pixels_o    = (line_q >= tmcg_pkg::BLANK_LINE) ? '0 : glyph_rd_q;
  assign column_o    = col_q;
  assign text_row_o  = row_q;
  assign scanline_o  = line_q;
  assign frame_end_o = col_last && line_last && row_last;

endmodule

// ----- rtl/core/text_mode_character_generator_top.sv -----
// Top level of the text-mode character generator.
//
//   channel   handshake             payload
//   command   start / busy          op_i, address_i, data_i
//   result    strobe_o (one cycle)  pixels_o, column_o, text_row_o, scanline_o, frame_end_o
//
// Writes are taken without leaving idle; op 3 is taken and dropped.
// A raster tick steps through screen read, glyph read, then the result
// beat on strobe_o, since each of the two memory reads is registered.
// After reset, busy stays high while screen memory clears.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module text_mode_character_generator_top #(
  parameter int COLUMNS       = tmcg_pkg::COLUMNS_DEF,
  parameter int ROWS          = tmcg_pkg::ROWS_DEF,
  parameter int LINES_PER_ROW = tmcg_pkg::LINES_PER_ROW_DEF,
  parameter int SCREEN_DEPTH  = tmcg_pkg::SCREEN_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [tmcg_pkg::OP_W-1:0]      op_i,
  input  logic [tmcg_pkg::ADDR_W-1:0]    address_i,
  input  logic [tmcg_pkg::DATA_W-1:0]    data_i,
  output logic                           strobe_o,
  output logic [tmcg_pkg::DATA_W-1:0]    pixels_o,
  output logic [tmcg_pkg::COL_W-1:0]     column_o,
  output logic [tmcg_pkg::ROW_W-1:0]     text_row_o,
  output logic [tmcg_pkg::LINE_W-1:0]    scanline_o,
  output logic                           frame_end_o
);

  tmcg_pkg::cmd_t    cmd;
  tmcg_pkg::status_t status;

  tmcg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (op_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  tmcg_datapath #(
    .COLUMNS       (COLUMNS),
    .ROWS          (ROWS),
    .LINES_PER_ROW (LINES_PER_ROW),
    .SCREEN_DEPTH  (SCREEN_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .address_i   (address_i),
    .data_i      (data_i),
    .strobe_o    (strobe_o),
    .pixels_o    (pixels_o),
    .column_o    (column_o),
    .text_row_o  (text_row_o),
    .scanline_o  (scanline_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// ----- rtl/core/tmcg_checker.sv -----
// Port-level checker for the text-mode character generator, bound to the top.
`timescale 1ns / 1ps
`include "text_mode_character_generator_top_assert.svh"

module tmcg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic [tmcg_pkg::OP_W-1:0]      op_i,
  input logic                           strobe_o,
  input logic [tmcg_pkg::DATA_W-1:0]    pixels_o,
  input logic [tmcg_pkg::LINE_W-1:0]    scanline_o
);

  logic tick_beat;
  logic blank_beat;

  assign tick_beat  = start && !busy && (op_i == tmcg_pkg::OP_TICK);
  assign blank_beat = strobe_o && (scanline_o >= tmcg_pkg::BLANK_LINE);

  // A tick beat yields its result once the screen and glyph reads are done.
  `TMCG_ASSERT(a_tick_result, tick_beat |-> ##2 strobe_o, "tick gave no result")
  // A result beat only appears while the block is busy with a tick.
  `TMCG_ASSERT(a_strobe_busy, strobe_o |-> busy, "result beat while idle")
  // Results are single-cycle beats.
  `TMCG_ASSERT_NEXT(a_strobe_single, strobe_o, !strobe_o, "result held for two cycles")
  // Blank scanlines carry no lit pixels.
  `TMCG_ASSERT(a_blank_line, blank_beat |-> (pixels_o == '0), "blank scanline lit")

endmodule

bind text_mode_character_generator_top tmcg_checker u_checker (.*);
